// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg: shared definitions of the streaming PNG encoder
// Field widths, defaults, register indexes, queue entry and geometry types,
// and the byte-wise CRC-32 step.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int CFG_W = 13;
    localparam int COL_W = 15;
    localparam int ROW_W = 13;
    localparam int RAW_W = 28;
    localparam int LEN_W = 32;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_HEIGHT  = 4096;
    localparam int DEF_BLOCK_BYTES = 65535;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;

    // One classified pixel byte on its way to the back end.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       col0;
        logic       last;
    } ent_t;

    // Image geometry latched at the start of a file.
    typedef struct packed {
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic             alpha;
        logic [RAW_W-1:0] raw;
    } geom_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/pse_fifo.sv =====
// ----------------------------------------------------------------------------
// pse_fifo: short register queue
// Decouples the classifying front end from the byte sequencer.
// ----------------------------------------------------------------------------
module pse_fifo #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg;
    logic [PW-1:0]    rd_reg;
    logic [CW-1:0]    cnt_reg;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop && valid)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push && !full) - CW'(pop && valid);
        end
    end
endmodule

// ===== rtl/pse_front.sv =====
// ----------------------------------------------------------------------------
// pse_front: configuration and pixel classification
// Holds the size registers, latches the geometry at the start of a file and
// tags each pixel byte as first, row start or last.
// ----------------------------------------------------------------------------
module pse_front import pse_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       pixel_byte,
    input  logic             q_full,
    output logic             q_push,
    output ent_t             q_data,
    output geom_t            geom
);
    typedef enum logic [1:0] {PH_SIG, PH_DATA, PH_DONE} phase_t;

    phase_t           phase_reg;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic             alpha_reg;
    logic [CFG_W-1:0] lw_reg, lh_reg;
    logic             la_reg;
    logic [COL_W-1:0] rowb_reg;
    logic [RAW_W-1:0] raw_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    logic [CFG_W-1:0] sw, sh;
    logic [COL_W-1:0] srowb, rowb, col, col_inc;
    logic [CFG_W-1:0] h;
    logic [ROW_W-1:0] row, row_inc;
    logic [RAW_W-1:0] sraw;
    logic             first, rowend, last, acc;

    always_comb
    begin
        if (width_reg == '0)
            sw = CFG_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            sw = CFG_W'(MAX_WIDTH);
        else
            sw = width_reg;
        if (height_reg == '0)
            sh = CFG_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            sh = CFG_W'(MAX_HEIGHT);
        else
            sh = height_reg;
        srowb = alpha_reg ? COL_W'({sw, 2'b00})
                          : COL_W'({sw, 1'b0}) + COL_W'(sw);
        sraw  = RAW_W'(sh) * RAW_W'(srowb + 1'b1);
        first = (phase_reg == PH_SIG);
        rowb  = first ? srowb : rowb_reg;
        h     = first ? sh : lh_reg;
        col   = first ? '0 : col_reg;
        row   = first ? '0 : row_reg;
        col_inc = col + 1'b1;
        rowend  = (col_inc >= rowb);
        row_inc = row + ROW_W'(rowend);
        last    = (row_inc >= h);
    end

    assign in_stall = (phase_reg != PH_DONE) && q_full;
    assign acc      = in_valid && !in_stall;
    assign q_push   = acc && (phase_reg != PH_DONE);
    assign q_data   = '{data: pixel_byte, first: first, col0: (col == '0), last: last};
    assign geom     = '{w: lw_reg, h: lh_reg, alpha: la_reg, raw: raw_reg};

    always_ff @(posedge clk)
    begin
        if (q_push && first)
        begin
            lw_reg   <= sw;
            lh_reg   <= sh;
            la_reg   <= alpha_reg;
            rowb_reg <= srowb;
            raw_reg  <= sraw;
        end
        if (q_push)
        begin
            col_reg <= rowend ? '0 : col_inc;
            row_reg <= row_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            alpha_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_ALPHA:  alpha_reg  <= cfg_data[0];
                default: ;
            endcase
            if (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_ALPHA})
            begin
                phase_reg <= PH_SIG;
            end
        end
        else if (q_push)
        begin
            phase_reg <= (rowend && last) ? PH_DONE : PH_DATA;
        end
    end
endmodule

// ===== rtl/pse_back.sv =====
// ----------------------------------------------------------------------------
// pse_back: byte sequencer
// Emits headers, stored block headers, filter and pixel bytes and trailers
// one byte per cycle while the output is not stalled, keeping the chunk CRC and the Adler-32 sums.
// ----------------------------------------------------------------------------
module pse_back import pse_pkg::*; #(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  ent_t       q_data,
    output logic       q_pop,
    input  geom_t      geom,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       file_end
);
    typedef enum logic [2:0] {S_IDLE, S_CALC, S_HEAD, S_RAW, S_TAIL} state_t;
    typedef enum logic [1:0] {CRC_KEEP, CRC_STEP, CRC_START} crc_op_t;

    localparam logic [RAW_W-1:0] BLK_R = RAW_W'(BLOCK_BYTES);
    localparam logic [16:0]      BLK_D = 17'(BLOCK_BYTES);

    // The block count is a round-up division by the block size. It is done
    // as a multiply by the scaled reciprocal, which is exact for every
    // dividend below 2^RAW_W.
    localparam int DIV_L = $clog2(BLOCK_BYTES);
    localparam int DIV_S = RAW_W + DIV_L;
    localparam int DIV_W = RAW_W + 1;
    localparam logic [RAW_W:0] DIV_M =
        DIV_W'(((64'd1 << DIV_S) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

    state_t           state_reg;
    ent_t             ent_reg;
    logic [6:0]       cnt_reg;
    logic [5:0]       idx_reg;
    logic             sel_reg;
    logic [31:0]      crc_reg;
    logic [15:0]      adl_reg, adh_reg;
    logic [15:0]      blk_reg;
    logic [RAW_W-1:0] rawr_reg;
    logic [RAW_W-1:0] dnum_reg, dq_reg;
    logic             ov_reg, rl_reg, fe_reg;
    logic [7:0]       ob_reg;

    logic [7:0]  byte_c, pix;
    crc_op_t     op_c;
    logic        final_c, active, go, put, out_free, load_now, data_step;
    logic [31:0] crcx, crc_new, idat;
    logic [15:0] n;
    logic [16:0] s1, s2;
    logic [15:0] adl_n, adh_n;
    logic [2*RAW_W:0] prod;

    assign crcx     = ~crc_reg;
    assign idat     = 32'(dq_reg) + 32'({dq_reg, 2'b00}) + 32'(geom.raw) + 32'd6;
    assign n        = (rawr_reg < BLK_R) ? rawr_reg[15:0] : BLK_D[15:0];
    assign pix      = sel_reg ? ent_reg.data : 8'd0;
    assign out_free = !ov_reg || !out_stall;
    assign active   = (state_reg == S_HEAD) || (state_reg == S_RAW) || (state_reg == S_TAIL);
    assign go       = active && (cnt_reg[6] || out_free);
    assign put      = go && !cnt_reg[6];
    assign data_step = go && (state_reg == S_RAW) && (blk_reg != '0);
    assign load_now = q_valid && ((state_reg == S_IDLE)
                      || (data_step && sel_reg && !ent_reg.last));
    assign q_pop    = load_now;
    assign prod     = dnum_reg * DIV_M;

    assign s1    = {1'b0, adl_reg} + {9'd0, pix};
    assign adl_n = (s1 >= ADLER_MOD) ? 16'(s1 - ADLER_MOD) : s1[15:0];
    assign s2    = {1'b0, adh_reg} + {1'b0, adl_n};
    assign adh_n = (s2 >= ADLER_MOD) ? 16'(s2 - ADLER_MOD) : s2[15:0];

    always_comb
    begin
        byte_c  = 8'd0;
        op_c    = CRC_KEEP;
        final_c = 1'b0;
        case (state_reg)
            S_HEAD:
            begin
                case (idx_reg) inside
                    6'd0:  byte_c = 8'h89;
                    6'd1:  byte_c = 8'h50;
                    6'd2:  byte_c = 8'h4E;
                    6'd3:  byte_c = 8'h47;
                    6'd4:  byte_c = 8'h0D;
                    6'd5:  byte_c = 8'h0A;
                    6'd6:  byte_c = 8'h1A;
                    6'd7:  byte_c = 8'h0A;
                    6'd11: byte_c = 8'h0D;
                    6'd12: byte_c = 8'h49;
                    6'd13: byte_c = 8'h48;
                    6'd14: byte_c = 8'h44;
                    6'd15: byte_c = 8'h52;
                    6'd18: byte_c = {3'b000, geom.w[12:8]};
                    6'd19: byte_c = geom.w[7:0];
                    6'd22: byte_c = {3'b000, geom.h[12:8]};
                    6'd23: byte_c = geom.h[7:0];
                    6'd24: byte_c = 8'h08;
                    6'd25: byte_c = geom.alpha ? 8'h06 : 8'h02;
                    6'd29: byte_c = crcx[31:24];
                    6'd30: byte_c = crcx[23:16];
                    6'd31: byte_c = crcx[15:8];
                    6'd32: byte_c = crcx[7:0];
                    6'd33: byte_c = idat[31:24];
                    6'd34: byte_c = idat[23:16];
                    6'd35: byte_c = idat[15:8];
                    6'd36: byte_c = idat[7:0];
                    6'd37: byte_c = 8'h49;
                    6'd38: byte_c = 8'h44;
                    6'd39: byte_c = 8'h41;
                    6'd40: byte_c = 8'h54;
                    6'd41: byte_c = 8'h78;
                    6'd42: byte_c = 8'h01;
                    default: byte_c = 8'h00;
                endcase
                case (idx_reg) inside
                    6'd12, 6'd37:              op_c = CRC_START;
                    [6'd13:6'd28], [6'd38:6'd42]: op_c = CRC_STEP;
                    default:                   op_c = CRC_KEEP;
                endcase
            end
            S_RAW:
            begin
                op_c = CRC_STEP;
                if (blk_reg == '0)
                begin
                    case (idx_reg)
                        6'd0:    byte_c = {7'd0, rawr_reg <= BLK_R};
                        6'd1:    byte_c = n[7:0];
                        6'd2:    byte_c = n[15:8];
                        6'd3:    byte_c = ~n[7:0];
                        default: byte_c = ~n[15:8];
                    endcase
                end
                else
                begin
                    byte_c  = pix;
                    final_c = sel_reg && !ent_reg.last;
                end
            end
            S_TAIL:
            begin
                case (idx_reg) inside
                    6'd0:  byte_c = adh_reg[15:8];
                    6'd1:  byte_c = adh_reg[7:0];
                    6'd2:  byte_c = adl_reg[15:8];
                    6'd3:  byte_c = adl_reg[7:0];
                    6'd4, 6'd16: byte_c = crcx[31:24];
                    6'd5, 6'd17: byte_c = crcx[23:16];
                    6'd6, 6'd18: byte_c = crcx[15:8];
                    6'd7, 6'd19: byte_c = crcx[7:0];
                    6'd12: byte_c = 8'h49;
                    6'd13: byte_c = 8'h45;
                    6'd14: byte_c = 8'h4E;
                    6'd15: byte_c = 8'h44;
                    default: byte_c = 8'h00;
                endcase
                case (idx_reg) inside
                    6'd12:                      op_c = CRC_START;
                    [6'd0:6'd3], [6'd13:6'd15]: op_c = CRC_STEP;
                    default:                    op_c = CRC_KEEP;
                endcase
                final_c = (idx_reg == 6'd19);
            end
            default: ;
        endcase
    end

    assign crc_new = crc_byte((op_c == CRC_START) ? CRC_INIT : crc_reg, byte_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            ob_reg    <= 8'd0;
            rl_reg    <= 1'b0;
            fe_reg    <= 1'b0;
        end
        else
        begin
            if (put && out_free)
            begin
                ov_reg <= 1'b1;
                ob_reg <= byte_c;
                rl_reg <= final_c || (cnt_reg == 7'd63);
                fe_reg <= (final_c || (cnt_reg == 7'd63)) && ent_reg.last;
            end
            else if (!out_stall)
                ov_reg <= 1'b0;
            if (go && !cnt_reg[6])
                cnt_reg <= cnt_reg + 1'b1;

            unique case (state_reg)
                S_IDLE: ;
                S_CALC:
                    state_reg <= S_HEAD;
                S_HEAD:
                    if (go && idx_reg == 6'd42)
                        state_reg <= S_RAW;
                S_RAW:
                    if (data_step && sel_reg)
                        state_reg <= ent_reg.last ? S_TAIL : S_IDLE;
                S_TAIL:
                    if (go && idx_reg == 6'd19)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase

            if (load_now)
            begin
                cnt_reg   <= '0;
                state_reg <= q_data.first ? S_CALC : S_RAW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && op_c != CRC_KEEP)
            crc_reg <= crc_new;

        case (state_reg)
            S_CALC:
            begin
                dq_reg  <= RAW_W'(prod >> DIV_S);
                idx_reg <= '0;
            end
            S_HEAD:
                if (go)
                begin
                    idx_reg <= (idx_reg == 6'd42) ? '0 : idx_reg + 1'b1;
                    if (idx_reg == 6'd42)
                    begin
                        rawr_reg <= geom.raw;
                        blk_reg  <= '0;
                        adl_reg  <= 16'd1;
                        adh_reg  <= 16'd0;
                    end
                end
            S_RAW:
                if (go)
                begin
                    if (blk_reg == '0)
                    begin
                        idx_reg <= (idx_reg == 6'd4) ? '0 : idx_reg + 1'b1;
                        if (idx_reg == 6'd4)
                            blk_reg <= n;
                    end
                    else
                    begin
                        adl_reg <= adl_n;
                        adh_reg <= adh_n;
                        blk_reg <= blk_reg - 1'b1;
                        if (rawr_reg != '0)
                            rawr_reg <= rawr_reg - 1'b1;
                        sel_reg <= 1'b1;
                        idx_reg <= '0;
                    end
                end
            S_TAIL:
                if (go)
                    idx_reg <= idx_reg + 1'b1;
            default: ;
        endcase

        if (load_now)
        begin
            ent_reg  <= q_data;
            sel_reg  <= !q_data.col0;
            idx_reg  <= '0;
            dnum_reg <= geom.raw + BLK_R - 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign run_last  = rl_reg;
    assign file_end  = fe_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 7'd64)
        else $error("per-beat result count ran past its cap");
    a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && fe_reg |-> rl_reg)
        else $error("file end seen without run end");
    a_raw_left: assert property (@(posedge clk) disable iff (!rst_n)
        data_step |-> rawr_reg != '0)
        else $error("data byte emitted beyond the computed stream size");
    a_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HEAD |-> dq_reg != '0)
        else $error("stream announced with no stored block");
endmodule

// ===== rtl/png_stream_encoder_stored.sv =====
// ----------------------------------------------------------------------------
// png_stream_encoder_stored: streaming PNG writer with stored deflate blocks
// Turns RGB or RGBA channel bytes into a complete PNG byte stream.
// ----------------------------------------------------------------------------
// Feed the channel bytes of one image in row order; the block emits the whole
// PNG file, one beat per output byte: the signature, IHDR, a single IDAT chunk
// holding a zlib stream of stored blocks with a zero filter byte ahead of every
// row and an Adler-32 trailer, then IEND. The size registers are sampled when
// the first pixel byte of a file is taken; writing any register restarts the
// file, and pixel bytes after the end of a file are taken and dropped. The
// output side runs at one byte per cycle while out_stall is low, set by the
// single output register, so a pixel byte costs one output byte inside a row,
// plus the filter byte at each row start and five bytes for each stored block
// header. The first byte of a file waits for the block count (a multiply by
// the reciprocal of the block size) and 43 header bytes; the last byte adds
// 20 trailer bytes. A queue of QUEUE_DEPTH beats sits between the input
// classifier and the byte sequencer so input keeps flowing while the output
// side is stalled, until the queue fills. run_last marks the final byte
// caused by an input beat and file_end the final byte of the file.
module png_stream_encoder_stored import pse_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       pixel_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             file_end
);
    // Classified beats travel front to back through the queue; the geometry
    // stays put for the whole file, so it is passed alongside.
    ent_t  push_ent, pop_ent;
    geom_t geom;
    logic  q_push, q_full, q_pop, q_valid;

    pse_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_byte (pixel_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_ent),
        .geom       (geom)
    );

    pse_fifo #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_ent),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_ent),
        .valid     (q_valid)
    );

    pse_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_ent),
        .q_pop     (q_pop),
        .geom      (geom),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .file_end  (file_end)
    );
endmodule
